// ===== rtl/core/fpfa_pkg.sv =====
// fpfa_pkg: shared codes, defaults and sequencer states of the partition allocator
// depends on nothing; used by fixed_partition_fit_allocator_top
package fpfa_pkg;

   localparam int DEF_PARTITIONS    = 8;
   localparam int DEF_PROCESS_SLOTS = 8;
   localparam int DEF_SIZE_BITS     = 16;

   localparam int BASE_BITS = 20;

   // operation codes
   localparam logic [1:0] OP_DEFINE    = 2'd0;
   localparam logic [1:0] OP_SUBMIT    = 2'd1;
   localparam logic [1:0] OP_TERMINATE = 2'd2;

   // fit policy codes
   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   // status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_PART_FULL  = 3'd1;
   localparam logic [2:0] ST_SLOT_FULL  = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
   localparam logic [2:0] ST_INVALID    = 3'd4;

   // result kinds
   localparam logic KIND_ASSIGN = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // register indexes
   localparam logic REG_FIT_POLICY = 1'b0;

   typedef enum logic [2:0] {
      S_IDLE,
      S_OPSCAN,
      S_FREE,
      S_SLOT,
      S_PSCAN,
      S_EMIT,
      S_STATUS
   } seq_state_type;

endpackage

// ===== rtl/core/fixed_partition_fit_allocator_top.sv =====
// fixed_partition_fit_allocator_top: fixed partition allocator with fit policies
// depends on fpfa_pkg
//
// Each request word defines a partition, submits a process or terminates one.
// Afterwards every waiting slot is tried in slot order. Each placement gives one
// assignment word, and one closing status word with last_result set ends the request.
// Partition sizes and bases sit in a synchronous memory that is read once per cycle
// in a pipelined scan. A request is accepted, a slot search finds a free slot or the
// named slot if there is one, and a terminate of a placed process then frees the
// lowest partition that the name owns. The placement pass then scans the partitions
// for each waiting slot, and each assignment word and the status word wait while the
// result channel stalls. One request is worked on at a time, and results wait in an
// output register. fit_policy is written over the csr port at byte address 0.
module fixed_partition_fit_allocator_top #(
   parameter int PARTITIONS    = fpfa_pkg::DEF_PARTITIONS,
   parameter int PROCESS_SLOTS = fpfa_pkg::DEF_PROCESS_SLOTS,
   parameter int SIZE_BITS     = fpfa_pkg::DEF_SIZE_BITS
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_process_name,
   input  logic [15:0] req_amount,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [2:0]  rsp_status_code,
   output logic [7:0]  rsp_placed_name,
   output logic [2:0]  rsp_partition_index,
   output logic [18:0] rsp_partition_base,
   output logic [15:0] rsp_internal_waste,
   output logic        rsp_last_result,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int PW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
   localparam int CW = $clog2(PARTITIONS + 1);
   localparam int SW = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
   localparam int BB = fpfa_pkg::BASE_BITS;
   localparam logic [CW-1:0] PART_MAX  = CW'(PARTITIONS);
   localparam logic [SW-1:0] SLOT_LAST = SW'(PROCESS_SLOTS - 1);

   // configuration register
   logic [1:0] fit_policy_ff;
   logic       csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == fpfa_pkg::REG_FIT_POLICY) ?
                       {30'd0, fit_policy_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_policy_ff <= fpfa_pkg::FIT_FIRST;
      end else if (csr_wr && csr_paddr[2] == fpfa_pkg::REG_FIT_POLICY) begin
         fit_policy_ff <= csr_pwdata[1:0];
      end
   end

   // partition memory: size and base
   logic [SIZE_BITS-1:0] mem_size [PARTITIONS];
   logic [BB-1:0]        mem_base [PARTITIONS];
   logic                 mem_we;
   logic [PW-1:0]        mem_waddr;
   logic [PW-1:0]        mem_raddr;
   logic [SIZE_BITS-1:0] rd_size_ff;
   logic [BB-1:0]        rd_base_ff;

   // flop state
   logic                 part_busy_ff  [PARTITIONS];
   logic [7:0]           part_owner_ff [PARTITIONS];
   logic [CW-1:0]        part_count_ff;
   logic [BB-1:0]        run_base_ff;
   logic [7:0]           slot_name_ff  [PROCESS_SLOTS];
   logic [SIZE_BITS-1:0] slot_size_ff  [PROCESS_SLOTS];
   logic                 slot_placed_ff[PROCESS_SLOTS];

   // sequencer registers
   fpfa_pkg::seq_state_type state_ff, state_in;
   logic [1:0]           op_ff;
   logic [7:0]           name_ff;
   logic [SIZE_BITS-1:0] amt_ff;
   logic [2:0]           status_ff;
   logic [SW-1:0]        si_ff;
   logic [CW-1:0]        pj_ff;
   logic                 chk_vld_ff;
   logic [PW-1:0]        chk_idx_ff;
   logic                 have_ff;
   logic [PW-1:0]        pick_idx_ff;
   logic [BB-1:0]        pick_base_ff;
   logic [SIZE_BITS-1:0] pick_left_ff;
   logic [SIZE_BITS-1:0] need_ff;
   logic [7:0]           pname_ff;

   logic [SIZE_BITS-1:0] amt_cut;
   logic                 accept;
   logic                 out_free;
   logic                 rsp_load;
   logic                 issue;
   logic                 fits;
   logic [SIZE_BITS-1:0] left;
   logic                 take;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_size[mem_waddr] <= amt_cut;
         mem_base[mem_waddr] <= run_base_ff;
      end
      rd_size_ff <= mem_size[mem_raddr];
      rd_base_ff <= mem_base[mem_raddr];
   end

   // output register
   logic        rsp_valid_ff;
   logic        rsp_kind_ff;
   logic [2:0]  rsp_status_ff;
   logic [7:0]  rsp_name_ff;
   logic [2:0]  rsp_index_ff;
   logic [18:0] rsp_base_ff;
   logic [15:0] rsp_waste_ff;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = rsp_kind_ff;
   assign rsp_status_code     = rsp_status_ff;
   assign rsp_placed_name     = rsp_name_ff;
   assign rsp_partition_index = rsp_index_ff;
   assign rsp_partition_base  = rsp_base_ff;
   assign rsp_internal_waste  = rsp_waste_ff;
   assign rsp_last_result     = rsp_kind_ff;

   assign amt_cut   = SIZE_BITS'(req_amount);
   assign req_ready = (state_ff == fpfa_pkg::S_IDLE);
   assign accept    = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign rsp_load  = out_free && (state_ff == fpfa_pkg::S_EMIT ||
                                   state_ff == fpfa_pkg::S_STATUS);
   assign mem_we    = accept && req_operation == fpfa_pkg::OP_DEFINE &&
                      amt_cut != '0 && part_count_ff < PART_MAX;
   assign mem_waddr = part_count_ff[PW-1:0];
   assign mem_raddr = pj_ff[PW-1:0];
   assign issue     = (state_ff == fpfa_pkg::S_PSCAN) && (pj_ff < part_count_ff);

   // fit test on the partition read last cycle
   assign fits = chk_vld_ff && !part_busy_ff[chk_idx_ff] && rd_size_ff >= need_ff;
   assign left = rd_size_ff - need_ff;
   always_comb begin
      take = 1'b0;
      if (fits) begin
         case (fit_policy_ff)
            fpfa_pkg::FIT_FIRST: take = !have_ff;
            fpfa_pkg::FIT_BEST:  take = !have_ff || left < pick_left_ff;
            fpfa_pkg::FIT_WORST: take = !have_ff || left > pick_left_ff;
            default:             take = 1'b0;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fpfa_pkg::S_IDLE: begin
            if (accept) begin
               if ((req_operation == fpfa_pkg::OP_SUBMIT &&
                    req_process_name != 8'd0 && amt_cut != '0) ||
                   (req_operation == fpfa_pkg::OP_TERMINATE &&
                    req_process_name != 8'd0))
                  state_in = fpfa_pkg::S_OPSCAN;
               else
                  state_in = fpfa_pkg::S_SLOT;
            end
         end
         fpfa_pkg::S_OPSCAN: begin
            if (op_ff == fpfa_pkg::OP_SUBMIT && slot_size_ff[si_ff] == '0)
               state_in = fpfa_pkg::S_SLOT;
            else if (op_ff == fpfa_pkg::OP_TERMINATE && slot_size_ff[si_ff] != '0 &&
                     slot_name_ff[si_ff] == name_ff)
               state_in = slot_placed_ff[si_ff] ? fpfa_pkg::S_FREE : fpfa_pkg::S_SLOT;
            else if (si_ff == SLOT_LAST)
               state_in = fpfa_pkg::S_SLOT;
         end
         fpfa_pkg::S_FREE: begin
            if (pj_ff >= part_count_ff)
               state_in = fpfa_pkg::S_SLOT;
            else if (part_busy_ff[pj_ff[PW-1:0]] && part_owner_ff[pj_ff[PW-1:0]] == name_ff)
               state_in = fpfa_pkg::S_SLOT;
         end
         fpfa_pkg::S_SLOT: begin
            if (slot_size_ff[si_ff] != '0 && !slot_placed_ff[si_ff])
               state_in = fpfa_pkg::S_PSCAN;
            else if (si_ff == SLOT_LAST)
               state_in = fpfa_pkg::S_STATUS;
         end
         fpfa_pkg::S_PSCAN: begin
            if (!issue && !chk_vld_ff) begin
               if (have_ff)
                  state_in = fpfa_pkg::S_EMIT;
               else if (si_ff == SLOT_LAST)
                  state_in = fpfa_pkg::S_STATUS;
               else
                  state_in = fpfa_pkg::S_SLOT;
            end
         end
         fpfa_pkg::S_EMIT: begin
            if (out_free)
               state_in = (si_ff == SLOT_LAST) ? fpfa_pkg::S_STATUS : fpfa_pkg::S_SLOT;
         end
         fpfa_pkg::S_STATUS: begin
            if (out_free)
               state_in = fpfa_pkg::S_IDLE;
         end
         default: state_in = fpfa_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= fpfa_pkg::S_IDLE;
      else
         state_ff <= state_in;
   end

   // datapath and table updates
   always_ff @(posedge clock) begin
      if (reset) begin
         part_count_ff <= '0;
         run_base_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         chk_vld_ff    <= 1'b0;
         have_ff       <= 1'b0;
         for (int p = 0; p < PARTITIONS; p++) begin
            part_busy_ff[p]  <= 1'b0;
            part_owner_ff[p] <= 8'd0;
         end
         for (int s = 0; s < PROCESS_SLOTS; s++) begin
            slot_name_ff[s]   <= 8'd0;
            slot_size_ff[s]   <= '0;
            slot_placed_ff[s] <= 1'b0;
         end
      end else begin
         // output word valid: load wins over a drain
         if (rsp_load)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
         chk_vld_ff <= issue;
         chk_idx_ff <= pj_ff[PW-1:0];
         case (state_ff)
            fpfa_pkg::S_IDLE: begin
               if (accept) begin
                  op_ff   <= req_operation;
                  name_ff <= req_process_name;
                  amt_ff  <= amt_cut;
                  si_ff   <= '0;
                  case (req_operation)
                     fpfa_pkg::OP_DEFINE: begin
                        if (amt_cut == '0)
                           status_ff <= fpfa_pkg::ST_INVALID;
                        else if (part_count_ff >= PART_MAX)
                           status_ff <= fpfa_pkg::ST_PART_FULL;
                        else begin
                           status_ff <= fpfa_pkg::ST_OK;
                           part_busy_ff[part_count_ff[PW-1:0]]  <= 1'b0;
                           part_owner_ff[part_count_ff[PW-1:0]] <= 8'd0;
                           run_base_ff   <= run_base_ff + BB'(amt_cut);
                           part_count_ff <= part_count_ff + 1'b1;
                        end
                     end
                     fpfa_pkg::OP_SUBMIT: begin
                        if (req_process_name == 8'd0 || amt_cut == '0)
                           status_ff <= fpfa_pkg::ST_INVALID;
                        else
                           status_ff <= fpfa_pkg::ST_SLOT_FULL;
                     end
                     fpfa_pkg::OP_TERMINATE: begin
                        if (req_process_name == 8'd0)
                           status_ff <= fpfa_pkg::ST_INVALID;
                        else
                           status_ff <= fpfa_pkg::ST_NOT_FOUND;
                     end
                     default: status_ff <= fpfa_pkg::ST_OK;
                  endcase
               end
            end
            // find a free slot or the named slot
            fpfa_pkg::S_OPSCAN: begin
               if (op_ff == fpfa_pkg::OP_SUBMIT && slot_size_ff[si_ff] == '0) begin
                  slot_name_ff[si_ff]   <= name_ff;
                  slot_size_ff[si_ff]   <= amt_ff;
                  slot_placed_ff[si_ff] <= 1'b0;
                  status_ff <= fpfa_pkg::ST_OK;
                  si_ff     <= '0;
               end else if (op_ff == fpfa_pkg::OP_TERMINATE && slot_size_ff[si_ff] != '0 &&
                            slot_name_ff[si_ff] == name_ff) begin
                  slot_name_ff[si_ff]   <= 8'd0;
                  slot_size_ff[si_ff]   <= '0;
                  slot_placed_ff[si_ff] <= 1'b0;
                  status_ff <= fpfa_pkg::ST_OK;
                  si_ff     <= '0;
                  pj_ff     <= '0;
               end else if (si_ff == SLOT_LAST)
                  si_ff <= '0;
               else
                  si_ff <= si_ff + 1'b1;
            end
            // release the lowest partition owned by the name
            fpfa_pkg::S_FREE: begin
               if (pj_ff < part_count_ff) begin
                  if (part_busy_ff[pj_ff[PW-1:0]] && part_owner_ff[pj_ff[PW-1:0]] == name_ff) begin
                     part_busy_ff[pj_ff[PW-1:0]]  <= 1'b0;
                     part_owner_ff[pj_ff[PW-1:0]] <= 8'd0;
                  end
                  pj_ff <= pj_ff + 1'b1;
               end
            end
            // pick the next waiting slot
            fpfa_pkg::S_SLOT: begin
               if (slot_size_ff[si_ff] != '0 && !slot_placed_ff[si_ff]) begin
                  need_ff  <= slot_size_ff[si_ff];
                  pname_ff <= slot_name_ff[si_ff];
                  pj_ff    <= '0;
                  have_ff  <= 1'b0;
               end else if (si_ff != SLOT_LAST)
                  si_ff <= si_ff + 1'b1;
            end
            // pipelined partition scan
            fpfa_pkg::S_PSCAN: begin
               if (issue)
                  pj_ff <= pj_ff + 1'b1;
               if (take) begin
                  have_ff      <= 1'b1;
                  pick_idx_ff  <= chk_idx_ff;
                  pick_base_ff <= rd_base_ff;
                  pick_left_ff <= left;
               end
               if (!issue && !chk_vld_ff && !have_ff && si_ff != SLOT_LAST)
                  si_ff <= si_ff + 1'b1;
            end
            // assignment word
            fpfa_pkg::S_EMIT: begin
               if (out_free) begin
                  rsp_kind_ff   <= fpfa_pkg::KIND_ASSIGN;
                  rsp_status_ff <= fpfa_pkg::ST_OK;
                  rsp_name_ff   <= pname_ff;
                  rsp_index_ff  <= 3'(pick_idx_ff);
                  rsp_base_ff   <= pick_base_ff[18:0];
                  rsp_waste_ff  <= 16'(pick_left_ff);
                  part_busy_ff[pick_idx_ff]  <= 1'b1;
                  part_owner_ff[pick_idx_ff] <= pname_ff;
                  slot_placed_ff[si_ff]      <= 1'b1;
                  have_ff <= 1'b0;
                  if (si_ff != SLOT_LAST)
                     si_ff <= si_ff + 1'b1;
               end
            end
            // closing status word
            fpfa_pkg::S_STATUS: begin
               if (out_free) begin
                  rsp_kind_ff   <= fpfa_pkg::KIND_STATUS;
                  rsp_status_ff <= status_ff;
                  rsp_name_ff   <= 8'd0;
                  rsp_index_ff  <= 3'd0;
                  rsp_base_ff   <= 19'd0;
                  rsp_waste_ff  <= 16'd0;
               end
            end
            default: ;
         endcase
      end
   end

endmodule
